@@ sv/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared item types and controller states for the set-associative cache
// tag and replacement controller.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int ADDR_W = 32;

  // Access kind codes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        way_used;
    logic              write_back;
    logic [ADDR_W-1:0] evicted_address;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

@@ sv/salc_set_ram.sv @@
// ----------------------------------------------------------------------------
// salc_set_ram
// One row per set: tag, recency, dirty and valid of every way. One write
// port and one read port, read data registered.
// ----------------------------------------------------------------------------
module salc_set_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 100
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/salc_update.sv @@
// ----------------------------------------------------------------------------
// salc_update
// Tag compare, victim choice and LRU update for one set row. Produces the
// row to write back and the result item.
// ----------------------------------------------------------------------------
module salc_update #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 32
) (
  input  logic [(NUM_WAYS * (32 - $clog2(BLOCK_BYTES) - $clog2(NUM_SETS)
                 + ((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1) + 2))-1:0] row,
  input  salc_pkg::in_item_t  item,
  output logic [(NUM_WAYS * (32 - $clog2(BLOCK_BYTES) - $clog2(NUM_SETS)
                 + ((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1) + 2))-1:0] new_row,
  output salc_pkg::out_item_t result
);

  localparam int OFF_W     = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int SET_IDX_W = (NUM_SETS > 1) ? SET_BITS : 1;
  localparam int TAG_W     = salc_pkg::ADDR_W - OFF_W - SET_BITS;
  localparam int ORD_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAY_W     = ORD_W;
  localparam int WAY_BITS  = TAG_W + ORD_W + 2;
  localparam int DIRTY_POS = TAG_W + ORD_W;
  localparam int VALID_POS = TAG_W + ORD_W + 1;
  localparam logic [ORD_W-1:0] ORD_OLDEST = ORD_W'(NUM_WAYS - 1);

  logic [TAG_W-1:0]     tag_in;
  logic [SET_IDX_W-1:0] set_idx;

  assign tag_in  = TAG_W'(item.address >> (OFF_W + SET_BITS));
  assign set_idx = SET_IDX_W'((item.address >> OFF_W) & 32'(NUM_SETS - 1));

  always_comb begin
    logic [TAG_W-1:0] tag_w;
    logic [ORD_W-1:0] ord_w;
    logic             vld_w;
    logic             drt_w;
    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic [ORD_W-1:0] hit_ord;
    logic             inv_any;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] lru_way;
    logic [TAG_W-1:0] lru_tag;
    logic             lru_dirty;
    logic [WAY_W-1:0] tgt_way;
    logic             evict;

    hit_any   = 1'b0;
    hit_way   = '0;
    hit_ord   = '0;
    inv_any   = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    lru_tag   = '0;
    lru_dirty = 1'b0;

    // Descending scan: the lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      tag_w = row[w*WAY_BITS +: TAG_W];
      ord_w = row[w*WAY_BITS + TAG_W +: ORD_W];
      drt_w = row[w*WAY_BITS + DIRTY_POS];
      vld_w = row[w*WAY_BITS + VALID_POS];
      if (vld_w && (tag_w == tag_in)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
        hit_ord = ord_w;
      end
      if (!vld_w) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
      // Valid orders form a permutation, so the oldest holds the top value
      if (vld_w && (ord_w == ORD_OLDEST)) begin
        lru_way   = WAY_W'(w);
        lru_tag   = tag_w;
        lru_dirty = drt_w;
      end
    end

    tgt_way = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
    evict   = !hit_any && !inv_any && lru_dirty;

    new_row = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_w = row[w*WAY_BITS +: TAG_W];
      ord_w = row[w*WAY_BITS + TAG_W +: ORD_W];
      drt_w = row[w*WAY_BITS + DIRTY_POS];
      vld_w = row[w*WAY_BITS + VALID_POS];
      if (WAY_W'(w) == tgt_way) begin
        new_row[w*WAY_BITS +: TAG_W]         = hit_any ? tag_w : tag_in;
        new_row[w*WAY_BITS + TAG_W +: ORD_W] = '0;
        new_row[w*WAY_BITS + DIRTY_POS]      = hit_any ? (drt_w | item.mode) : item.mode;
        new_row[w*WAY_BITS + VALID_POS]      = 1'b1;
      end else if (vld_w && (!hit_any || (ord_w <= hit_ord))) begin
        // Age every other valid way on a fill, only the younger ones on a hit
        new_row[w*WAY_BITS + TAG_W +: ORD_W] = ord_w + ORD_W'(1);
      end
    end

    result.hit        = hit_any;
    result.way_used   = 2'(tgt_way);
    result.write_back = evict;
    result.evicted_address = evict ?
      ((32'(lru_tag) << (OFF_W + SET_BITS)) | (32'(set_idx) << OFF_W)) : '0;
  end

endmodule

@@ sv/set_assoc_cache_lru_controller_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller_top: the set row of an accepted item is read
// from the single-port-pair set RAM; the row is written back and the result
// registered once the result register is free, and only then is a new item
// taken. Reset clears the store, one row write per cycle, with in_stall high.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_controller_top #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  salc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output salc_pkg::out_item_t out_data
);

  // NUM_SETS and BLOCK_BYTES are powers of two
  localparam int OFF_W     = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int SET_IDX_W = (NUM_SETS > 1) ? SET_BITS : 1;
  localparam int TAG_W     = salc_pkg::ADDR_W - OFF_W - SET_BITS;
  localparam int ORD_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W     = NUM_WAYS * (TAG_W + ORD_W + 2);

  salc_pkg::state_t    state_r, state_nxt;
  logic [SET_IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  salc_pkg::in_item_t  item_r, item_nxt;
  logic                out_valid_r, out_valid_nxt;
  salc_pkg::out_item_t out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic                 ram_wr_en;
  logic [SET_IDX_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0]     ram_wr_data;
  logic [SET_IDX_W-1:0] ram_rd_addr;
  logic [ROW_W-1:0]     ram_rd_data;
  logic [ROW_W-1:0]     upd_row;
  salc_pkg::out_item_t  upd_result;
  logic [SET_IDX_W-1:0] item_set;

  assign in_stall  = (state_r != salc_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign ram_rd_addr = SET_IDX_W'((in_data.address >> OFF_W) & 32'(NUM_SETS - 1));
  assign item_set    = SET_IDX_W'((item_r.address >> OFF_W) & 32'(NUM_SETS - 1));

  salc_set_ram #(
    .DEPTH  (NUM_SETS),
    .ADDR_W (SET_IDX_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_accept),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  salc_update #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_update (
    .row     (ram_rd_data),
    .item    (item_r),
    .new_row (upd_row),
    .result  (upd_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salc_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    item_nxt      = item_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = item_set;
    ram_wr_data   = upd_row;

    unique case (state_r)
      salc_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r;
        ram_wr_data = '0;
        clr_idx_nxt = clr_idx_r + SET_IDX_W'(1);
        if (clr_idx_r == SET_IDX_W'(NUM_SETS - 1)) begin
          clr_idx_nxt = '0;
          state_nxt   = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        if (in_accept) begin
          item_nxt  = in_data;
          state_nxt = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        // Hold the row until the result register can take the item
        if (out_free) begin
          ram_wr_en     = 1'b1;
          out_data_nxt  = upd_result;
          out_valid_nxt = 1'b1;
          state_nxt     = salc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = salc_pkg::ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == salc_pkg::ST_LOOKUP))
    else $error("accepted item did not enter lookup");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hit) |->
      (!out_data_r.write_back && (out_data_r.evicted_address == '0)))
    else $error("hit reported an eviction");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == salc_pkg::ST_LOOKUP))
    else $error("result appeared without a lookup");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salc_pkg::ST_CLEAR) |-> (!out_valid_r && in_stall))
    else $error("activity during clearing pass");
`endif

endmodule
